// ===== src/assert_macros.svh =====
// assertion macros shared by the min/max locate modules
// expects clk and rst in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in one cycle implies consequence in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mml_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and format helpers for the min/max locate block
// no dependencies
package mml_pkg;

  localparam int COORD_BITS = 12;
  localparam int WIDTH_BITS = 13;
  localparam int LANES      = 4;

  localparam logic [2:0] FMT_U8  = 3'd0;
  localparam logic [2:0] FMT_S8  = 3'd1;
  localparam logic [2:0] FMT_U16 = 3'd2;
  localparam logic [2:0] FMT_S16 = 3'd3;
  localparam logic [2:0] FMT_S32 = 3'd4;

  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;

  localparam logic signed [31:0] U8_MAX  = 32'sd255;
  localparam logic signed [31:0] S8_MAX  = 32'sd127;
  localparam logic signed [31:0] S8_MIN  = -32'sd128;
  localparam logic signed [31:0] U16_MAX = 32'sd65535;
  localparam logic signed [31:0] S16_MAX = 32'sd32767;
  localparam logic signed [31:0] S16_MIN = -32'sd32768;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [31:0] sample_0;
    logic [31:0] sample_1;
    logic [31:0] sample_2;
    logic [31:0] sample_3;
    logic        frame_end;
  } pix_item_t;

  typedef struct packed {
    logic [1:0]            channel_index;
    logic signed [31:0]    min_value;
    logic signed [31:0]    max_value;
    logic [COORD_BITS-1:0] min_row;
    logic [COORD_BITS-1:0] min_col;
    logic [COORD_BITS-1:0] max_row;
    logic [COORD_BITS-1:0] max_col;
    logic                  last_channel;
  } res_item_t;

  typedef struct packed {
    logic [2:0]            sample_format;
    logic [2:0]            channel_count;
    logic [WIDTH_BITS-1:0] image_width;
  } cfg_t;

  // decoded pixel waiting in the queue
  typedef struct packed {
    logic [LANES-1:0][31:0] value;
    logic [COORD_BITS-1:0]  row;
    logic [COORD_BITS-1:0]  col;
    logic                   frame_end;
  } pix_entry_t;

  typedef struct packed {
    logic signed [31:0]    min_value;
    logic signed [31:0]    max_value;
    logic [COORD_BITS-1:0] min_row;
    logic [COORD_BITS-1:0] min_col;
    logic [COORD_BITS-1:0] max_row;
    logic [COORD_BITS-1:0] max_col;
  } lane_t;

  function automatic logic signed [31:0] decode(input logic [2:0] fmt, input logic [31:0] raw);
    logic signed [31:0] v;
    case (fmt)
      FMT_U8:  v = {24'd0, raw[7:0]};
      FMT_S8:  v = {{24{raw[7]}}, raw[7:0]};
      FMT_U16: v = {16'd0, raw[15:0]};
      FMT_S16: v = {{16{raw[15]}}, raw[15:0]};
      default: v = raw;
    endcase
    return v;
  endfunction

  function automatic lane_t lane_init(input logic [2:0] fmt);
    lane_t l;
    l = '0;
    case (fmt)
      FMT_U8: begin
        l.min_value = U8_MAX;
        l.max_value = '0;
      end
      FMT_S8: begin
        l.min_value = S8_MAX;
        l.max_value = S8_MIN;
      end
      FMT_U16: begin
        l.min_value = U16_MAX;
        l.max_value = '0;
      end
      FMT_S16: begin
        l.min_value = S16_MAX;
        l.max_value = S16_MIN;
      end
      default: begin
        l.min_value = S32_MAX;
        l.max_value = S32_MIN;
      end
    endcase
    return l;
  endfunction

endpackage

// ===== src/mml_fifo.sv =====
`timescale 1ns / 1ps
// small register queue between the front and back parts
// depends on assert_macros.svh
`include "assert_macros.svh"
module mml_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "queue count beyond depth")
  `ASSERT_NEXT(a_push_grows, push && !pop, count == $past(count) + CW'(1), "push lost")
endmodule

// ===== src/mml_front.sv =====
`timescale 1ns / 1ps
// front part: sample decode and raster position counting
// depends on mml_pkg
module mml_front (
  input  logic                          clk,
  input  logic                          rst,
  input  mml_pkg::cfg_t                 cfg,
  input  logic                          restart,
  input  logic                          take,
  input  mml_pkg::pix_item_t            pix,
  output mml_pkg::pix_entry_t           entry
);
  localparam int CB = mml_pkg::COORD_BITS;
  localparam int CW = (CB + 1 > mml_pkg::WIDTH_BITS) ? CB + 1 : mml_pkg::WIDTH_BITS;

  logic [CB-1:0] row_count;
  logic [CB-1:0] col_count;
  logic [CW-1:0] width_ext;
  logic [CW-1:0] width_lim;
  logic [CW-1:0] width_eff;
  logic [CB-1:0] last_col;

  always_comb begin
    width_ext = CW'(cfg.image_width);
    width_lim = CW'(1) << CB;
    if (width_ext == '0) begin
      width_eff = CW'(1);
    end else if (width_ext > width_lim) begin
      width_eff = width_lim;
    end else begin
      width_eff = width_ext;
    end
    last_col = CB'(width_eff - CW'(1));
  end

  always_comb begin
    entry.value[0]  = mml_pkg::decode(cfg.sample_format, pix.sample_0);
    entry.value[1]  = mml_pkg::decode(cfg.sample_format, pix.sample_1);
    entry.value[2]  = mml_pkg::decode(cfg.sample_format, pix.sample_2);
    entry.value[3]  = mml_pkg::decode(cfg.sample_format, pix.sample_3);
    entry.row       = row_count;
    entry.col       = col_count;
    entry.frame_end = pix.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_count <= '0;
      col_count <= '0;
    end else if (take) begin
      if (pix.frame_end) begin
        row_count <= '0;
        col_count <= '0;
      end else if (col_count == last_col) begin
        col_count <= '0;
        row_count <= row_count + CB'(1);
      end else begin
        col_count <= col_count + CB'(1);
      end
    end
  end
endmodule

// ===== src/mml_back.sv =====
`timescale 1ns / 1ps
// back part: running extremes per channel with first-hit positions
// depends on mml_pkg
module mml_back #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  mml_pkg::cfg_t       cfg,
  input  logic                restart,
  input  logic [2:0]          restart_fmt,
  input  logic                pop,
  input  mml_pkg::pix_entry_t head,
  output mml_pkg::lane_t      snap [MAX_CHANNELS]
);
  mml_pkg::lane_t run      [MAX_CHANNELS];
  mml_pkg::lane_t run_next [MAX_CHANNELS];

  always_comb begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      run_next[k] = run[k];
      if ($signed(head.value[k]) < run[k].min_value) begin
        run_next[k].min_value = $signed(head.value[k]);
        run_next[k].min_row   = head.row;
        run_next[k].min_col   = head.col;
      end
      if ($signed(head.value[k]) > run[k].max_value) begin
        run_next[k].max_value = $signed(head.value[k]);
        run_next[k].max_row   = head.row;
        run_next[k].max_col   = head.col;
      end
      snap[k] = run_next[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (rst) begin
        run[k] <= mml_pkg::lane_init(mml_pkg::FMT_U8);
      end else if (restart) begin
        run[k] <= mml_pkg::lane_init(restart_fmt);
      end else if (pop && head.frame_end) begin
        run[k] <= mml_pkg::lane_init(cfg.sample_format);
      end else if (pop) begin
        run[k] <= run_next[k];
      end
    end
  end
endmodule

// ===== src/mml_emit.sv =====
`timescale 1ns / 1ps
// result sequencer: holds a frame's extremes and sends one beat per channel
// depends on mml_pkg and assert_macros.svh
`include "assert_macros.svh"
module mml_emit #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  mml_pkg::cfg_t       cfg,
  input  logic                load,
  input  mml_pkg::lane_t      snap [MAX_CHANNELS],
  output logic                load_ok,
  output logic                res_valid,
  input  logic                res_ready,
  output mml_pkg::res_item_t  res
);
  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  mml_pkg::lane_t hold [MAX_CHANNELS];
  logic           busy;
  logic [IW-1:0]  idx;
  logic [2:0]     last_raw;
  logic [IW-1:0]  last_idx;
  logic           at_last;

  always_comb begin
    if (cfg.channel_count == '0) begin
      last_raw = '0;
    end else if (cfg.channel_count > 3'(MAX_CHANNELS)) begin
      last_raw = 3'(MAX_CHANNELS - 1);
    end else begin
      last_raw = cfg.channel_count - 3'd1;
    end
    last_idx = IW'(last_raw);
    at_last  = (idx == last_idx);
  end

  assign res_valid = busy;
  assign load_ok   = !busy || (res_ready && at_last);

  always_comb begin
    res.channel_index = 2'(idx);
    res.min_value     = hold[idx].min_value;
    res.max_value     = hold[idx].max_value;
    res.min_row       = hold[idx].min_row;
    res.min_col       = hold[idx].min_col;
    res.max_row       = hold[idx].max_row;
    res.max_col       = hold[idx].max_col;
    res.last_channel  = at_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        hold[k] <= snap[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && res_ready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IW'(1);
      end
    end
  end

  `ASSERT_NEXT(a_load_starts, load, res_valid && idx == '0, "frame load did not start at channel 0")
endmodule

// ===== src/per_channel_min_max_locate_unit.sv =====
`timescale 1ns / 1ps
// throughput: one pixel per cycle while the queue is not full; a frame end holds in
//   the queue until the previous frame's per-channel beats (one per cycle per active
//   channel while res_ready is high) are out
// reset: config to unsigned 8 bit, 3 channels, width 640; extremes at format bounds;
//   queue and result sequencer empty
module per_channel_min_max_locate_unit #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  mml_pkg::pix_item_t  pix,
  output logic                res_valid,
  input  logic                res_ready,
  output mml_pkg::res_item_t  res
);
  mml_pkg::cfg_t       cfg;
  logic                restart;
  logic [2:0]          restart_fmt;
  logic                take;
  mml_pkg::pix_entry_t entry;
  mml_pkg::pix_entry_t head;
  logic                q_full;
  logic                q_empty;
  logic                pop;
  logic                load_ok;
  mml_pkg::lane_t      snap [MAX_CHANNELS];

  assign restart     = cfg_we && (cfg_index == mml_pkg::REG_SAMPLE_FORMAT ||
                                  cfg_index == mml_pkg::REG_CHANNEL_COUNT ||
                                  cfg_index == mml_pkg::REG_IMAGE_WIDTH);
  assign restart_fmt = (cfg_index == mml_pkg::REG_SAMPLE_FORMAT) ? cfg_data[2:0]
                                                                 : cfg.sample_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= mml_pkg::FMT_U8;
      cfg.channel_count <= 3'd3;
      cfg.image_width   <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        mml_pkg::REG_SAMPLE_FORMAT: cfg.sample_format <= cfg_data[2:0];
        mml_pkg::REG_CHANNEL_COUNT: cfg.channel_count <= cfg_data[2:0];
        mml_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix_ready = !q_full;
  assign take      = pix_valid && pix_ready;
  assign pop       = !q_empty && (!head.frame_end || load_ok);

  mml_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .take    (take),
    .pix     (pix),
    .entry   (entry)
  );

  mml_fifo #(
    .W     ($bits(mml_pkg::pix_entry_t)),
    .DEPTH (2)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wdata (entry),
    .full  (q_full),
    .pop   (pop),
    .rdata (head),
    .empty (q_empty)
  );

  mml_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .restart_fmt (restart_fmt),
    .pop         (pop),
    .head        (head),
    .snap        (snap)
  );

  mml_emit #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .load      (pop && head.frame_end),
    .snap      (snap),
    .load_ok   (load_ok),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for per_channel_min_max_locate_unit: directed table, random frames
// a local model of the per-channel extremes and positions predicts the result beats,
// apart from directed rows whose stats are written out by hand; depends on mml_pkg and the unit under src
module tb_top;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE = 16;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] FMT_UNKNOWN = 3'd7;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    bit                  is_reg;
    logic [1:0]          idx;
    logic [12:0]         val;
    mml_pkg::pix_item_t  px;
    bit                  typed;
    mml_pkg::res_item_t  want;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;
  logic pix_valid;
  logic pix_ready;
  mml_pkg::pix_item_t pix;
  logic res_valid;
  logic res_ready;
  mml_pkg::res_item_t res;

  // local model of the block
  logic [2:0] cur_fmt;
  logic [2:0] cur_chans;
  logic [12:0] cur_width;
  logic signed [31:0] lo_val [mml_pkg::LANES];
  logic signed [31:0] hi_val [mml_pkg::LANES];
  logic [mml_pkg::COORD_BITS-1:0] lo_row [mml_pkg::LANES];
  logic [mml_pkg::COORD_BITS-1:0] lo_col [mml_pkg::LANES];
  logic [mml_pkg::COORD_BITS-1:0] hi_row [mml_pkg::LANES];
  logic [mml_pkg::COORD_BITS-1:0] hi_col [mml_pkg::LANES];
  logic [mml_pkg::COORD_BITS-1:0] row_at;
  logic [mml_pkg::COORD_BITS-1:0] col_at;

  mml_pkg::res_item_t pending_stats[$];
  int mismatches = 0;
  int cycles = 0;
  bit tx_live = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit hold_req = 1'b0;
  bit rx_holding = 1'b0;

  per_channel_min_max_locate_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [2:0] eff_fmt();
    return (cur_fmt > mml_pkg::FMT_S32) ? mml_pkg::FMT_S32 : cur_fmt;
  endfunction

  function automatic int live_chans();
    if (cur_chans == 3'd0) return 1;
    if (cur_chans > mml_pkg::LANES) return mml_pkg::LANES;
    return int'(cur_chans);
  endfunction

  function automatic int pixels_per_row();
    if (cur_width == 13'd0) return 1;
    if (cur_width > (1 << mml_pkg::COORD_BITS)) return 1 << mml_pkg::COORD_BITS;
    return int'(cur_width);
  endfunction

  function automatic logic signed [31:0] sample_value(input logic [31:0] raw);
    case (eff_fmt())
      mml_pkg::FMT_U8:  return int'(raw[7:0]);
      mml_pkg::FMT_S8:  return raw[7] ? int'(raw[7:0]) - 256 : int'(raw[7:0]);
      mml_pkg::FMT_U16: return int'(raw[15:0]);
      mml_pkg::FMT_S16: return raw[15] ? int'(raw[15:0]) - 65536 : int'(raw[15:0]);
      default: return $signed(raw);
    endcase
  endfunction

  function automatic void rearm_extremes();
    logic signed [31:0] top;
    logic signed [31:0] bottom;
    case (eff_fmt())
      mml_pkg::FMT_U8: begin
        top = mml_pkg::U8_MAX;
        bottom = '0;
      end
      mml_pkg::FMT_S8: begin
        top = mml_pkg::S8_MAX;
        bottom = mml_pkg::S8_MIN;
      end
      mml_pkg::FMT_U16: begin
        top = mml_pkg::U16_MAX;
        bottom = '0;
      end
      mml_pkg::FMT_S16: begin
        top = mml_pkg::S16_MAX;
        bottom = mml_pkg::S16_MIN;
      end
      default: begin
        top = mml_pkg::S32_MAX;
        bottom = mml_pkg::S32_MIN;
      end
    endcase
    for (int k = 0; k < mml_pkg::LANES; k++) begin
      lo_val[k] = top;
      hi_val[k] = bottom;
      lo_row[k] = '0;
      lo_col[k] = '0;
      hi_row[k] = '0;
      hi_col[k] = '0;
    end
    row_at = '0;
    col_at = '0;
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [12:0] val);
    case (idx)
      mml_pkg::REG_SAMPLE_FORMAT: cur_fmt = val[2:0];
      mml_pkg::REG_CHANNEL_COUNT: cur_chans = val[2:0];
      mml_pkg::REG_IMAGE_WIDTH:   cur_width = val;
      default: return;
    endcase
    rearm_extremes();
  endfunction

  // fold one accepted pixel into the running extremes, queue stats on frame end
  task automatic locate_pixel(input mml_pkg::pix_item_t p, input bit typed,
                              input mml_pkg::res_item_t want);
    logic [31:0] raw [mml_pkg::LANES];
    logic signed [31:0] v;
    mml_pkg::res_item_t r;
    int n;
    raw[0] = p.sample_0;
    raw[1] = p.sample_1;
    raw[2] = p.sample_2;
    raw[3] = p.sample_3;
    n = live_chans();
    for (int k = 0; k < n; k++) begin
      v = sample_value(raw[k]);
      if (v < lo_val[k]) begin
        lo_val[k] = v;
        lo_row[k] = row_at;
        lo_col[k] = col_at;
      end
      if (v > hi_val[k]) begin
        hi_val[k] = v;
        hi_row[k] = row_at;
        hi_col[k] = col_at;
      end
    end
    if (int'(col_at) + 1 >= pixels_per_row()) begin
      col_at = '0;
      row_at = row_at + 1'b1;
    end else begin
      col_at = col_at + 1'b1;
    end
    if (p.frame_end) begin
      for (int k = 0; k < n; k++) begin
        r.channel_index = k[1:0];
        r.min_value = lo_val[k];
        r.max_value = hi_val[k];
        r.min_row = lo_row[k];
        r.min_col = lo_col[k];
        r.max_row = hi_row[k];
        r.max_col = hi_col[k];
        r.last_channel = (k == n - 1);
        pending_stats.push_back(typed ? want : r);
      end
      rearm_extremes();
    end
  endtask

  task automatic stop_offer();
    if (tx_live) begin
      pix_valid <= 1'b0;
      tx_live = 1'b0;
    end
  endtask

  task automatic send_pixel(input mml_pkg::pix_item_t p, input bit typed,
                            input mml_pkg::res_item_t want);
    if (!tx_calm && $urandom_range(0, 6) == 0) begin
      stop_offer();
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    pix <= p;
    pix_valid <= 1'b1;
    tx_live = 1'b1;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    locate_pixel(p, typed, want);
  endtask

  task automatic drain();
    if (tx_live) begin
      stop_offer();
      @(posedge clk);
    end
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0, 1: return r;
      2: return {30'd0, r[1:0]};
      3: return {{30{1'b1}}, r[1:0]};
      4: return r & 32'hffff_ff03;
      5: return {r[31:16], 14'd0, r[1:0]};
      6: return r[2] ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return r[2] ? {r[31:16], 16'h8000} : {r[31:8], 8'h7f};
    endcase
  endfunction

  function automatic mml_pkg::pix_item_t rand_pixel(input logic fe);
    mml_pkg::pix_item_t p;
    p.sample_0 = pick_sample();
    p.sample_1 = pick_sample();
    p.sample_2 = pick_sample();
    p.sample_3 = pick_sample();
    p.frame_end = fe;
    return p;
  endfunction

  function automatic logic [12:0] pick_width();
    case ($urandom_range(0, 5))
      0: return 13'd1;
      1: return 13'($urandom_range(2, 5));
      2: return 13'd4096;
      3: return 13'($urandom_range(4097, 8191));
      4: return 13'd0;
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic step_t reg_row(input logic [1:0] idx, input logic [12:0] val);
    step_t s;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    s.px = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t pix_row(input logic [31:0] a, input logic [31:0] b,
                                    input logic [31:0] c, input logic [31:0] d,
                                    input logic fe);
    step_t s;
    s = reg_row(mml_pkg::REG_SAMPLE_FORMAT, '0);
    s.is_reg = 1'b0;
    s.px.sample_0 = a;
    s.px.sample_1 = b;
    s.px.sample_2 = c;
    s.px.sample_3 = d;
    s.px.frame_end = fe;
    return s;
  endfunction

  // single-channel frame end with the stats written out by hand
  function automatic step_t known_row(input logic [31:0] a,
                                      input logic signed [31:0] lo, input logic signed [31:0] hi,
                                      input int lr, input int lc, input int hr, input int hc);
    step_t s;
    s = pix_row(a, $urandom, $urandom, $urandom, 1'b1);
    s.typed = 1'b1;
    s.want.channel_index = 2'd0;
    s.want.min_value = lo;
    s.want.max_value = hi;
    s.want.min_row = lr[mml_pkg::COORD_BITS-1:0];
    s.want.min_col = lc[mml_pkg::COORD_BITS-1:0];
    s.want.max_row = hr[mml_pkg::COORD_BITS-1:0];
    s.want.max_col = hc[mml_pkg::COORD_BITS-1:0];
    s.want.last_channel = 1'b1;
    return s;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_stats
    mml_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_stats.size() == 0) begin
        $error("result beat with nothing pending, channel %0d", res.channel_index);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        check_field("channel_index", want.channel_index, res.channel_index);
        check_field("min_value", want.min_value, res.min_value);
        check_field("max_value", want.max_value, res.max_value);
        check_field("min_row", want.min_row, res.min_row);
        check_field("min_col", want.min_col, res.min_col);
        check_field("max_row", want.max_row, res.max_row);
        check_field("max_col", want.max_col, res.max_col);
        check_field("last_channel", want.last_channel, res.last_channel);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : result_sink
    forever begin
      if (hold_req) begin
        res_ready <= 1'b0;
        rx_holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
        hold_req = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    step_t script[$];
    int items;
    int len;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= mml_pkg::REG_SAMPLE_FORMAT;
    cfg_data <= '0;
    pix_valid <= 1'b0;
    pix <= '0;
    cur_fmt = mml_pkg::FMT_U8;
    cur_chans = 3'd3;
    cur_width = 13'd640;
    rearm_extremes();

    // reset config: 3 channels of unsigned 8, fourth lane ignored
    script.push_back(pix_row(32'h1234_5600, 32'hffff_ffff, 32'h0000_0080, 32'h7f, 1'b1));
    script.push_back(reg_row(mml_pkg::REG_CHANNEL_COUNT, 13'd1));
    script.push_back(reg_row(mml_pkg::REG_IMAGE_WIDTH, 13'd2));
    script.push_back(pix_row(32'hffff_ff80, 0, 0, 0, 1'b0));
    script.push_back(known_row(32'h0000_007f, 127, 128, 0, 1, 0, 0));
    // ties keep the first position, max never beats the lower bound
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_S8));
    script.push_back(pix_row(32'h0000_0080, 0, 0, 0, 1'b0));
    script.push_back(known_row(32'hffff_ff80, mml_pkg::S8_MIN, mml_pkg::S8_MIN, 0, 0, 0, 0));
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_U16));
    script.push_back(pix_row(32'hffff_0000, 0, 0, 0, 1'b0));
    script.push_back(known_row(32'h0000_ffff, 0, mml_pkg::U16_MAX, 0, 0, 0, 1));
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_S16));
    script.push_back(pix_row(32'h0000_8000, 0, 0, 0, 1'b0));
    script.push_back(known_row(32'hffff_7fff, mml_pkg::S16_MIN, mml_pkg::S16_MAX,
                               0, 0, 0, 1));
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_S32));
    script.push_back(pix_row(32'h8000_0000, 0, 0, 0, 1'b0));
    script.push_back(known_row(32'h7fff_ffff, mml_pkg::S32_MIN, mml_pkg::S32_MAX,
                               0, 0, 0, 1));
    // unknown format reads as signed 32
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, {10'h3ff, FMT_UNKNOWN}));
    script.push_back(known_row(32'hffff_ffff, -1, -1, 0, 0, 0, 0));
    // channel count clamps at both ends, width clamps at both ends
    script.push_back(reg_row(mml_pkg::REG_CHANNEL_COUNT, 13'd0));
    script.push_back(pix_row($urandom, $urandom, $urandom, $urandom, 1'b1));
    script.push_back(reg_row(mml_pkg::REG_CHANNEL_COUNT, 13'd7));
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_U8));
    script.push_back(reg_row(mml_pkg::REG_IMAGE_WIDTH, 13'd0));
    script.push_back(pix_row(32'hff, 32'h0, 32'haa, 32'h55, 1'b0));
    script.push_back(pix_row(32'h0, 32'hff, 32'h55, 32'haa, 1'b0));
    script.push_back(pix_row(32'h80, 32'h80, 32'h7f, 32'h01, 1'b1));
    script.push_back(reg_row(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_S32));
    script.push_back(reg_row(mml_pkg::REG_IMAGE_WIDTH, 13'd8191));
    script.push_back(pix_row(32'hffff_ffff, 32'h0, 32'haaaa_aaaa, 32'h5555_5555, 1'b0));
    script.push_back(pix_row(32'h0, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 1'b1));
    // a register write drops the partial frame
    script.push_back(pix_row(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 1'b0));
    script.push_back(reg_row(mml_pkg::REG_IMAGE_WIDTH, 13'd3));
    script.push_back(pix_row(32'h5, 32'h6, 32'h7, 32'h8, 1'b0));
    // write to an unlisted index leaves the frame running
    script.push_back(reg_row(REG_UNUSED, 13'h1fff));
    script.push_back(pix_row(32'h4, 32'h9, 32'h7, 32'hffff_fff8, 1'b1));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_pixel(script[i].px, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if (ph == 5) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      if (ph == 0) begin
        write_reg(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_U8);
        write_reg(mml_pkg::REG_CHANNEL_COUNT, 13'd4);
        write_reg(mml_pkg::REG_IMAGE_WIDTH, 13'd4096);
      end else if (ph == 1) begin
        write_reg(mml_pkg::REG_SAMPLE_FORMAT, mml_pkg::FMT_S32);
        write_reg(mml_pkg::REG_CHANNEL_COUNT, 13'd1);
        write_reg(mml_pkg::REG_IMAGE_WIDTH, 13'd1);
      end else begin
        write_reg(mml_pkg::REG_SAMPLE_FORMAT, {10'($urandom), 3'($urandom_range(0, 7))});
        write_reg(mml_pkg::REG_CHANNEL_COUNT, {10'($urandom), 3'($urandom_range(0, 7))});
        write_reg(mml_pkg::REG_IMAGE_WIDTH, pick_width());
      end
      items = 0;
      while (items < 10) begin
        len = $urandom_range(1, 8);
        for (int j = 0; j < len; j++) send_pixel(rand_pixel(j == len - 1), 1'b0, '0);
        items += len;
        if ($urandom_range(0, 5) == 0) drain();
      end
      // broken frame, cut short by the next register write
      if (ph < 5 && $urandom_range(0, 1) == 1) begin
        len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++) send_pixel(rand_pixel(1'b0), 1'b0, '0);
      end

      // sink holds off while short frames keep coming, so the unit backs up
      if (ph == 4) begin
        write_reg(mml_pkg::REG_CHANNEL_COUNT, 13'd4);
        write_reg(mml_pkg::REG_IMAGE_WIDTH, 13'd2);
        tx_calm = 1'b1;
        hold_req = 1'b1;
        while (!rx_holding) @(posedge clk);
        for (int j = 0; j < 24; j++) begin
          send_pixel(rand_pixel(1'($urandom_range(0, 1))), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
